### hw/rtl/cos_sim_pkg.sv
// ----------------------------------------------------------------------------
// cos_sim_pkg
// Shared constants for the streamed cosine similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package cos_sim_pkg;

	// default element width and vector length the accumulators are sized for
	localparam int unsigned ELEMENT_BITS_DEF = 16;
	localparam int unsigned MAX_LENGTH_DEF   = 1024;

	// result format: signed Q1.15
	localparam int unsigned SIM_BITS    = 16;
	localparam int unsigned Q_FRAC_BITS = 15;

	// quotient bits developed by the divider; one more than the fraction
	// so that every clamped value can be told apart
	localparam int unsigned QUOT_BITS = Q_FRAC_BITS + 1;

	localparam logic [SIM_BITS-1:0] SIM_POS_MAX = {1'b0, {(SIM_BITS-1){1'b1}}};
	localparam logic [SIM_BITS-1:0] SIM_NEG_MAG = {1'b1, {(SIM_BITS-1){1'b0}}};

endpackage

`default_nettype wire

### hw/rtl/cos_sim_if.sv
// ----------------------------------------------------------------------------
// cos_sim_if
// Valid/ready channels: element pairs in, similarity results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cos_sim_in_if #(
	parameter int unsigned ELEMENT_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [ELEMENT_BITS-1:0] elem_a;
	logic signed [ELEMENT_BITS-1:0] elem_b;
	logic                           last_elem;

	modport source (output valid, output elem_a, output elem_b, output last_elem,
		input ready);
	modport sink (input valid, input elem_a, input elem_b, input last_elem,
		output ready);
endinterface

interface cos_sim_out_if;
	import cos_sim_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SIM_BITS-1:0] similarity;
	logic                       undefined;

	modport source (output valid, output similarity, output undefined, input ready);
	modport sink (input valid, input similarity, input undefined, output ready);
endinterface

`default_nettype wire

### hw/rtl/cosine_similarity.sv
// ----------------------------------------------------------------------------
// cosine_similarity
// Streamed cosine similarity of two integer vectors, signed Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   elems  : one element pair (elem_a, elem_b) per beat, last_elem on the
//            final pair of the vectors. Ready is high only while idle.
//   result : one beat per vector pair, sent after the last element; carries
//            the similarity and an undefined flag (either magnitude zero,
//            similarity then 0).
// Pairs: each element pair occupies the block until its three products are
//   summed; all three pass through the one shared multiplier, one per cycle.
// Finish: after a last pair, the shared subtractor runs both square roots
//   one bit a cycle and then the 16-step restoring division; the division
//   is skipped when the quotient saturates or the result is undefined.
// Reset: clears the sums and the sequencer, drops any pending result.
// Stall: a finished result waits in the output register; if the previous
//   result has not been taken, the sequencer holds in its finish state and
//   the sums stay until the beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity #(
	parameter int unsigned ELEMENT_BITS = cos_sim_pkg::ELEMENT_BITS_DEF,
	parameter int unsigned MAX_LENGTH   = cos_sim_pkg::MAX_LENGTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	cos_sim_in_if.sink     elems,
	cos_sim_out_if.source  result
);
	import cos_sim_pkg::*;

	// Accumulators wrap beyond MAX_LENGTH pairs, as intended.
	localparam int unsigned ACC_BITS = 2 * ELEMENT_BITS + $clog2(MAX_LENGTH);
	// Floor square root of an ACC_BITS value fits SQ_BITS bits.
	localparam int unsigned SQ_BITS  = (ACC_BITS + 1) / 2;
	localparam int unsigned DEN_BITS = 2 * SQ_BITS;
	localparam int unsigned SUB_W    = DEN_BITS + 1;
	localparam int unsigned MUL_W    =
		((ELEMENT_BITS > SQ_BITS) ? ELEMENT_BITS : SQ_BITS) + 1;
	localparam int unsigned PROD_W   = 2 * MUL_W;
	localparam int unsigned CNT_W    = $clog2(QUOT_BITS);

	// Highest even bit position below ACC_BITS: first trial bit of the root.
	localparam logic [ACC_BITS-1:0] BIT_TOP =
		{{(ACC_BITS-1){1'b0}}, 1'b1} << (2 * (SQ_BITS - 1));
	localparam logic [CNT_W-1:0] CNT_START = CNT_W'(QUOT_BITS - 1);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_MUL_AB  = 12'b0000_0000_0010,
		ST_MUL_AA  = 12'b0000_0000_0100,
		ST_MUL_BB  = 12'b0000_0000_1000,
		ST_ACC_B   = 12'b0000_0001_0000,
		ST_SQRT_A  = 12'b0000_0010_0000,
		ST_SQRT_B  = 12'b0000_0100_0000,
		ST_MUL_DEN = 12'b0000_1000_0000,
		ST_SAT     = 12'b0001_0000_0000,
		ST_DIV     = 12'b0010_0000_0000,
		ST_FIN     = 12'b0100_0000_0000,
		ST_SPARE   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// latched input beat
	logic signed [ELEMENT_BITS-1:0] a_q, b_q;
	logic                           last_q;

	// running sums
	logic [ACC_BITS-1:0] dot_q, mag_a_q, mag_b_q;

	// shared multiplier and its result register
	logic signed [MUL_W-1:0]  mul_x, mul_y;
	logic signed [PROD_W-1:0] mul_p, prod_q;

	// shared subtractor: x - y, ge when no borrow
	logic [SUB_W-1:0] sub_x, sub_y;
	logic [SUB_W:0]   sub_d;
	logic             sub_ge;

	// square root iteration
	logic [ACC_BITS-1:0] n_q, res_q, bit_q, res_next;
	logic [ACC_BITS:0]   root_try;
	logic [SQ_BITS-1:0]  sa_q, sb_q;

	// division
	logic [DEN_BITS-1:0]  den, rem_q;
	logic                 nbit_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 und_q;

	// result shaping
	logic                dot_neg;
	logic [ACC_BITS-1:0] dmag;
	logic [ACC_BITS-1:0] acc_sel, acc_sum;
	logic [SIM_BITS-1:0] quot_clamp, sim_fin;
	logic                out_load;

	logic                       out_valid_q;
	logic signed [SIM_BITS-1:0] sim_q;
	logic                       und_out_q;

	assign elems.ready       = (state_q == ST_IDLE);
	assign result.valid      = out_valid_q;
	assign result.similarity = sim_q;
	assign result.undefined  = und_out_q;

	assign den     = prod_q[DEN_BITS-1:0];
	assign dot_neg = dot_q[ACC_BITS-1];
	assign dmag    = dot_neg ? (~dot_q + 1'b1) : dot_q;

	// Multiplier operands: the three element products, then sa * sb.
	always_comb begin
		unique case (state_q)
			ST_MUL_AB: begin
				mul_x = MUL_W'(a_q);
				mul_y = MUL_W'(b_q);
			end
			ST_MUL_AA: begin
				mul_x = MUL_W'(a_q);
				mul_y = MUL_W'(a_q);
			end
			ST_MUL_BB: begin
				mul_x = MUL_W'(b_q);
				mul_y = MUL_W'(b_q);
			end
			ST_MUL_DEN: begin
				mul_x = $signed(MUL_W'(sa_q));
				mul_y = $signed(MUL_W'(sb_q));
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign mul_p = mul_x * mul_y;

	// One adder folds the registered product into the sum it belongs to.
	always_comb begin
		unique case (state_q)
			ST_MUL_AA: acc_sel = dot_q;
			ST_MUL_BB: acc_sel = mag_a_q;
			ST_ACC_B:  acc_sel = mag_b_q;
			default:   acc_sel = '0;
		endcase
	end

	assign acc_sum = acc_sel + prod_q[ACC_BITS-1:0];

	// Subtractor operands: root trial, saturation test, division step.
	assign root_try = {1'b0, res_q} + {1'b0, bit_q};

	always_comb begin
		unique case (state_q)
			ST_SQRT_A, ST_SQRT_B: begin
				sub_x = SUB_W'(n_q);
				sub_y = SUB_W'(root_try);
			end
			ST_SAT: begin
				// quotient reaches 2^16 exactly when dmag >= 2 * den
				sub_x = SUB_W'(dmag);
				sub_y = {den, 1'b0};
			end
			ST_DIV: begin
				sub_x = {rem_q, nbit_q};
				sub_y = {1'b0, den};
			end
			default: begin
				sub_x = '0;
				sub_y = '0;
			end
		endcase
	end

	assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
	assign sub_ge = !sub_d[SUB_W];

	assign res_next = sub_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// Clamp the magnitude, then apply the sign of the dot product.
	always_comb begin
		if (dot_neg) begin
			quot_clamp = (quot_q > QUOT_BITS'(SIM_NEG_MAG)) ? SIM_NEG_MAG
				: SIM_BITS'(quot_q);
			sim_fin = ~quot_clamp + 1'b1;
		end else begin
			quot_clamp = (quot_q > QUOT_BITS'(SIM_POS_MAX)) ? SIM_POS_MAX
				: SIM_BITS'(quot_q);
			sim_fin = quot_clamp;
		end
	end

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (elems.valid) state_d = ST_MUL_AB;
			ST_MUL_AB:  state_d = ST_MUL_AA;
			ST_MUL_AA:  state_d = ST_MUL_BB;
			ST_MUL_BB:  state_d = ST_ACC_B;
			ST_ACC_B:   state_d = last_q ? ST_SQRT_A : ST_IDLE;
			ST_SQRT_A:  if (bit_q[0]) state_d = ST_SQRT_B;
			ST_SQRT_B:  if (bit_q[0]) state_d = ST_MUL_DEN;
			ST_MUL_DEN: state_d = ST_SAT;
			ST_SAT:     state_d = sub_ge ? ST_FIN : ST_DIV;
			ST_DIV:     if (cnt_q == '0) state_d = ST_FIN;
			ST_FIN:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Control state and sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dot_q       <= '0;
			mag_a_q     <= '0;
			mag_b_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_MUL_AA) begin
				dot_q <= acc_sum;
			end
			if (state_q == ST_MUL_BB) begin
				mag_a_q <= acc_sum;
			end
			if (state_q == ST_ACC_B) begin
				mag_b_q <= acc_sum;
			end
			if (out_load) begin
				dot_q   <= '0;
				mag_a_q <= '0;
				mag_b_q <= '0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (elems.valid && elems.ready) begin
			a_q    <= elems.elem_a;
			b_q    <= elems.elem_b;
			last_q <= elems.last_elem;
		end

		if (state_q == ST_MUL_AB || state_q == ST_MUL_AA || state_q == ST_MUL_BB
				|| state_q == ST_MUL_DEN) begin
			prod_q <= mul_p;
		end

		unique case (state_q)
			ST_ACC_B: begin
				n_q   <= mag_a_q;
				res_q <= '0;
				bit_q <= BIT_TOP;
			end
			ST_SQRT_A, ST_SQRT_B: begin
				if (bit_q[0]) begin
					// root done: restart on the second magnitude
					n_q   <= mag_b_q;
					res_q <= '0;
					bit_q <= BIT_TOP;
					if (state_q == ST_SQRT_A) begin
						sa_q <= res_next[SQ_BITS-1:0];
					end else begin
						sb_q <= res_next[SQ_BITS-1:0];
					end
				end else begin
					if (sub_ge) begin
						n_q <= sub_d[ACC_BITS-1:0];
					end
					res_q <= res_next;
					bit_q <= bit_q >> 2;
				end
			end
			ST_SAT: begin
				und_q  <= (den == '0);
				// saturated: all ones clamps to the right bound
				quot_q <= '1;
				rem_q  <= DEN_BITS'(dmag >> 1);
				nbit_q <= dmag[0];
				cnt_q  <= CNT_START;
			end
			ST_DIV: begin
				quot_q <= {quot_q[QUOT_BITS-2:0], sub_ge};
				rem_q  <= sub_ge ? sub_d[DEN_BITS-1:0] : {rem_q[DEN_BITS-2:0], nbit_q};
				nbit_q <= 1'b0;
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			sim_q     <= und_q ? '0 : $signed(sim_fin);
			und_out_q <= und_q;
		end
	end

`ifndef NO_ASSERTIONS
	// an undefined result always carries a zero similarity
	a_und_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.undefined |-> result.similarity == '0)
		else $error("undefined result with nonzero similarity");

	// an accepted beat takes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		elems.valid && elems.ready |=> !elems.ready)
		else $error("ready held after accepting a beat");

	// sums are clear once a result has been handed over
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_FIN && state_q == ST_IDLE
		|-> dot_q == '0 && mag_a_q == '0 && mag_b_q == '0)
		else $error("sums not cleared after result");

	// the division remainder stays below the denominator
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < den)
		else $error("division remainder out of range");
`endif

endmodule

`default_nettype wire

### tb/cosine_similarity_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_checker
// Watches both channels of the cosine similarity block, folds every element
// pair beat into its own running sums, and compares each result beat with
// the oldest predicted similarity.
// ----------------------------------------------------------------------------
module cosine_similarity_checker (
	input  wire    clk,
	input  wire    arst_n,
	cos_sim_in_if  elems,
	cos_sim_out_if result,
	output int     fail_count,
	output int     pending,
	output int     result_count,
	output int     undef_count,
	output int     clamp_count
);
	import cos_sim_pkg::*;

	localparam int unsigned EW    = ELEMENT_BITS_DEF;
	localparam int unsigned ACC_W = 42;

	typedef struct packed {
		logic [SIM_BITS-1:0] similarity;
		logic                undefined;
	} sim_beat_t;

	logic [ACC_W-1:0] dot_acc;
	logic [ACC_W-1:0] mag_a_acc;
	logic [ACC_W-1:0] mag_b_acc;
	sim_beat_t        expected_sims[$];

	// floor square root, one root bit per trial from the top down
	function automatic logic [31:0] root_floor(input logic [ACC_W-1:0] n);
		logic [31:0] root;
		logic [31:0] trial;
		logic [63:0] sq;
		root = '0;
		for (int k = 21; k >= 0; k--) begin
			trial = root | (32'd1 << k);
			sq    = 64'(trial) * 64'(trial);
			if (sq <= 64'(n))
				root = trial;
		end
		return root;
	endfunction

	// fold one pair into the sums; on the last pair queue the similarity
	task automatic fold_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
			input logic last);
		logic signed [2*EW-1:0] p_ab;
		logic signed [2*EW-1:0] p_aa;
		logic signed [2*EW-1:0] p_bb;
		logic [63:0]            denom;
		logic [63:0]            dmag;
		logic [63:0]            quot;
		logic                   neg;
		sim_beat_t              beat;
		p_ab = a * b;
		p_aa = a * a;
		p_bb = b * b;
		dot_acc   = dot_acc   + {{(ACC_W-2*EW){p_ab[2*EW-1]}}, p_ab};
		mag_a_acc = mag_a_acc + {{(ACC_W-2*EW){p_aa[2*EW-1]}}, p_aa};
		mag_b_acc = mag_b_acc + {{(ACC_W-2*EW){p_bb[2*EW-1]}}, p_bb};
		if (last) begin
			denom = 64'(root_floor(mag_a_acc)) * 64'(root_floor(mag_b_acc));
			if (denom == 0) begin
				beat.similarity = '0;
				beat.undefined  = 1'b1;
				undef_count++;
			end else begin
				neg  = dot_acc[ACC_W-1];
				dmag = neg ? (64'd1 << ACC_W) - 64'(dot_acc) : 64'(dot_acc);
				quot = (dmag << Q_FRAC_BITS) / denom;
				beat.undefined = 1'b0;
				if (neg) begin
					if (quot > 64'(SIM_NEG_MAG)) begin
						quot = 64'(SIM_NEG_MAG);
						clamp_count++;
					end
					beat.similarity = -quot[SIM_BITS-1:0];
				end else begin
					if (quot > 64'(SIM_POS_MAX)) begin
						quot = 64'(SIM_POS_MAX);
						clamp_count++;
					end
					beat.similarity = quot[SIM_BITS-1:0];
				end
			end
			expected_sims.push_back(beat);
			dot_acc   = '0;
			mag_a_acc = '0;
			mag_b_acc = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sim_beat_t want;
		if (!arst_n) begin
			dot_acc      = '0;
			mag_a_acc    = '0;
			mag_b_acc    = '0;
			fail_count   = 0;
			result_count = 0;
			undef_count  = 0;
			clamp_count  = 0;
			expected_sims.delete();
		end else begin
			// compare outgoing beats first, so a beat never meets its own prediction
			if (result.valid && result.ready) begin
				result_count++;
				if (expected_sims.size() == 0) begin
					$error("result beat with nothing expected: similarity %0d undefined %0b",
						$signed(result.similarity), result.undefined);
					fail_count++;
				end else begin
					want = expected_sims.pop_front();
					if (result.similarity !== want.similarity) begin
						$error("similarity: expected %0d, got %0d",
							$signed(want.similarity), $signed(result.similarity));
						fail_count++;
					end
					if (result.undefined !== want.undefined) begin
						$error("undefined: expected %0b, got %0b",
							want.undefined, result.undefined);
						fail_count++;
					end
				end
			end
			if (elems.valid && elems.ready)
				fold_pair(elems.elem_a, elems.elem_b, elems.last_elem);
		end
		pending = expected_sims.size();
	end

endmodule

### tb/tb_cosine_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity
// Streams element pairs of vector pairs into the cosine similarity block:
// a directed set of corner vectors, then random vectors of mixed shapes.
// Both sides idle in bursts, and the result side holds off once for a long
// stretch. The checker beside the block predicts and compares every result
// beat.
// ----------------------------------------------------------------------------
module tb_cosine_similarity;
	import cos_sim_pkg::*;

	localparam int unsigned EW = ELEMENT_BITS_DEF;

	// no beat on either channel for this long means the block has hung
	localparam int WATCHDOG_LIMIT = 4000;
	// long result hold-off, well past the time the block needs to fill up
	localparam int HOLD_CYCLES    = 400;
	// settle time after the last result, beyond the block's result latency
	localparam int DRAIN_CYCLES   = 100;
	localparam int RANDOM_PAIRS   = 880;
	// the closing part of the random phase runs without idling
	localparam int CALM_PAIRS     = 150;

	typedef enum int {
		VEC_RANDOM,
		VEC_SMALL,
		VEC_SAME,
		VEC_NEGATED,
		VEC_NEAR,
		VEC_SPARSE,
		VEC_EXTREME
	} vec_shape_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bit idle_on     = 1'b1;
	bit hold_req    = 1'b0;
	bit hold_served = 1'b0;

	int pairs_sent;
	int vectors_sent;
	int idle_cycles = 0;

	int fail_count;
	int pending;
	int result_count;
	int undef_count;
	int clamp_count;

	cos_sim_in_if #(.ELEMENT_BITS(EW)) elems_if ();
	cos_sim_out_if                     result_if ();

	cosine_similarity i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elems  (elems_if),
		.result (result_if)
	);

	cosine_similarity_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.elems        (elems_if),
		.result       (result_if),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.undef_count  (undef_count),
		.clamp_count  (clamp_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one element pair and hold it until the block takes it. Every
	// call starts and ends at a falling edge, so valid only ever changes
	// there; an idle burst drops valid first and raises it again later.
	task automatic send_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
			input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			elems_if.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		elems_if.valid     = 1'b1;
		elems_if.elem_a    = a;
		elems_if.elem_b    = b;
		elems_if.last_elem = last;
		do
			@(posedge clk);
		while (!elems_if.ready);
		@(negedge clk);
		pairs_sent++;
		if (last)
			vectors_sent++;
	endtask

	function automatic logic signed [EW-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0:       return {1'b1, {(EW-1){1'b0}}};
			1:       return {1'b0, {(EW-1){1'b1}}};
			2:       return '1;
			3:       return '0;
			default: return EW'(1);
		endcase
	endfunction

	// Result side: ready high by default, dropped in short random bursts,
	// and once dropped for a long hold-off counted here in its own cycles.
	initial begin
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_served) begin
				result_if.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_served = 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_if.ready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				result_if.ready = 1'b1;
			end
		end
	end

	// Watchdog: count cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((elems_if.valid && elems_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, pending);
				$display("** cosine_similarity: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int                     rand_pairs;
		int                     len;
		int                     noise;
		vec_shape_t             shape;
		logic signed [EW-1:0]   a;
		logic signed [EW-1:0]   b;

		rand_pairs         = 0;
		pairs_sent         = 0;
		vectors_sent       = 0;
		elems_if.valid     = 1'b0;
		elems_if.elem_a    = '0;
		elems_if.elem_b    = '0;
		elems_if.last_elem = 1'b0;

		// hold reset, then release it between edges
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed corners. Single-pair vectors at the extremes: the ratio is exactly
		// one, so the positive result clamps and the negative one just fits.
		send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sh7FFF, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7FFF, 1'b1);
		// zero magnitude on one side, then on both
		send_pair(16'sd0, 16'sd12345, 1'b1);
		send_pair(-16'sd1, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd0, 1'b1);
		// orthogonal vectors give a defined zero
		send_pair(16'sd1, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd1, 1'b1);
		// a plain three-element vector pair
		send_pair(16'sd3, 16'sd4, 1'b0);
		send_pair(16'sd4, -16'sd3, 1'b0);
		send_pair(-16'sd5, 16'sd12, 1'b1);
		// root of two floors to one: ratio of two, clamped either way
		send_pair(16'sd1, 16'sd1, 1'b0);
		send_pair(16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd1, -16'sd1, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		// alternating bit patterns
		send_pair(16'sh5555, 16'shAAAA, 1'b0);
		send_pair(16'shAAAA, 16'sh5555, 1'b1);

		// Random vectors, mostly short, in a mix of shapes.
		while (rand_pairs < RANDOM_PAIRS) begin
			if (rand_pairs >= RANDOM_PAIRS - CALM_PAIRS)
				idle_on = 1'b0;
			// midway, stall the result side while pairs keep coming
			if (!hold_req && rand_pairs >= RANDOM_PAIRS / 2)
				hold_req = 1'b1;
			case ($urandom_range(0, 19)) inside
				[0:11]:  len = $urandom_range(1, 6);
				[12:17]: len = $urandom_range(7, 32);
				default: len = $urandom_range(33, 120);
			endcase
			shape = vec_shape_t'($urandom_range(VEC_RANDOM, VEC_EXTREME));
			for (int i = 0; i < len; i++) begin
				a = EW'($urandom);
				b = EW'($urandom);
				case (shape)
					VEC_SMALL: begin
						a = EW'($urandom_range(0, 16) - 8);
						b = EW'($urandom_range(0, 16) - 8);
					end
					VEC_SAME:    b = a;
					VEC_NEGATED: b = -a;
					VEC_NEAR: begin
						noise = $urandom_range(0, 64);
						b = a + EW'(noise - 32);
					end
					VEC_SPARSE: begin
						if ($urandom_range(0, 2) != 0)
							a = '0;
						if ($urandom_range(0, 2) != 0)
							b = '0;
					end
					VEC_EXTREME: begin
						a = pick_extreme();
						b = pick_extreme();
					end
					default: ;
				endcase
				send_pair(a, b, i == len - 1);
			end
			rand_pairs += len;
		end
		elems_if.valid     = 1'b0;
		elems_if.last_elem = 1'b0;

		// drain: wait for every predicted result, then let the block settle
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d element pairs in %0d vector pairs, corners and random shapes",
			pairs_sent, vectors_sent);
		$display("result beats checked: %0d, undefined: %0d, saturated: %0d",
			result_count, undef_count, clamp_count);
		if (fail_count == 0 && pending == 0) begin
			$display("** cosine_similarity: PASSED **");
		end else begin
			$display("** cosine_similarity: FAILED **");
		end
		$finish;
	end

endmodule
